@@ rtl/pse_pkg.sv @@
// Shared types and constants for the polyline stroke extruder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;
  localparam int InDataW = 96;
  localparam int OutDataW = 136;
  localparam logic CfgWidth = 1'b0;
  localparam logic CfgColor = 1'b1;
  localparam logic [31:0] WidthReset = 32'h0001_0000;
  localparam logic [31:0] ColorReset = 32'hFFFF_FFFF;

  // controller -> datapath
  typedef struct packed {
    logic load_in;     // capture the accepted point
    logic start_a;     // start offset work for the held point
    logic start_b;     // start offset work for the last point
    logic shift_hist;  // move held point to prior, input to held
  } pse_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;
    logic done;
    logic nonzero;
    logic same_pt;     // input point equals the held point in x and z
  } pse_sts_t;
endpackage
`default_nettype wire

@@ rtl/pse_datapath.sv @@
// Datapath: point registers, normalize, bit-serial square root and divider.
// Depends on pse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pse_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pse_pkg::pse_cmd_t cmd,
  output pse_pkg::pse_sts_t      sts,
  input  wire logic [31:0]       in_x,
  input  wire logic [31:0]       in_h,
  input  wire logic [31:0]       in_z,
  input  wire logic              first_dir,
  input  wire logic [31:0]       stroke_width,
  output logic signed [32:0]     off_x,
  output logic signed [32:0]     off_z,
  output logic signed [31:0]     base_x,
  output logic signed [31:0]     base_z,
  output logic [31:0]            base_h
);
  import pse_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NORM = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_MULX = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic signed [31:0] cur_x, cur_z, cur_h;
  logic signed [31:0] pend_x, pend_z, pend_h, prior_x, prior_z;
  logic [2:0] st;
  logic [32:0] ax, az;
  logic sx, sz;
  logic [61:0] rad;
  logic [31:0] root;
  logic [4:0] cnt;
  logic [31:0] num;
  logic [32:0] rem;
  logic [31:0] quo, qx;
  logic sel_z;
  logic nz;

  // direction operands
  logic signed [32:0] dx, dz;
  always_comb begin
    if (cmd.start_b) begin
      dx = 33'(cur_x) - 33'(pend_x);
      dz = 33'(cur_z) - 33'(pend_z);
    end else if (first_dir) begin
      dx = 33'(cur_x) - 33'(pend_x);
      dz = 33'(cur_z) - 33'(pend_z);
    end else begin
      dx = 33'(cur_x) - 33'(prior_x);
      dz = 33'(cur_z) - 33'(prior_z);
    end
  end

  logic [32:0] mx;
  assign mx = (ax > az) ? ax : az;

  // square root step: two bits per cycle of rad
  logic [33:0] trial;
  logic [33:0] rem_sq;
  logic [33:0] rem_sq_sh;
  assign rem_sq_sh = {rem_sq[31:0], rad[61:60]};
  assign trial = {root, 2'b01};

  // division step: shift-subtract over the low dividend half
  logic [33:0] dshift;
  logic [33:0] dden;
  assign dshift = {rem, num[31]};
  assign dden = {1'b0, root, 1'b0};

  // dividend |c| * width + len; the high half preloads the remainder
  logic [29:0] mul_a;
  logic [31:0] len_add;
  logic [63:0] num_load;
  assign mul_a = (st == S_DIV) ? az[29:0] : ax[29:0];
  assign len_add = (st == S_DIV) ? root : {root[30:0], rem_sq_sh >= trial};
  assign num_load = 64'(mul_a * stroke_width) + 64'(len_add);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      unique case (st)
        S_IDLE: if (cmd.start_a || cmd.start_b) begin
          ax <= dx[32] ? 33'(-dx) : 33'(dx);
          az <= dz[32] ? 33'(-dz) : 33'(dz);
          sx <= dx[32];
          sz <= dz[32];
          nz <= (dx != 0) || (dz != 0);
          st <= ((dx != 0) || (dz != 0)) ? S_NORM : S_DONE;
        end
        S_NORM: begin
          if (mx >= 33'h4000_0000) begin
            ax <= ax >> 1;
            az <= az >> 1;
          end else if (mx < 33'h2000_0000) begin
            ax <= ax << 1;
            az <= az << 1;
          end else begin
            st <= S_MULX;
            cnt <= 5'd0;
          end
        end
        S_MULX: begin
          // sum of squares from two 30x30 products, x first, then z
          if (cnt == 5'd0) begin
            rad <= 62'(ax[29:0] * ax[29:0]);
            cnt <= 5'd1;
          end else begin
            rad <= rad + 62'(az[29:0] * az[29:0]);
            root <= '0;
            rem_sq <= '0;
            cnt <= 5'd30;
            st <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (rem_sq_sh >= trial) begin
            rem_sq <= rem_sq_sh - trial;
            root <= {root[30:0], 1'b1};
          end else begin
            rem_sq <= rem_sq_sh;
            root <= {root[30:0], 1'b0};
          end
          rad <= {rad[59:0], 2'b00};
          if (cnt == 5'd0) begin
            sel_z <= 1'b0;
            st <= S_DIV;
            cnt <= 5'd31;
            rem <= 33'(num_load[63:32]);
            num <= num_load[31:0];
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        S_DIV: begin
          if (dshift >= dden) begin
            rem <= 33'(dshift - dden);
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= dshift[32:0];
            quo <= {quo[30:0], 1'b0};
          end
          num <= {num[30:0], 1'b0};
          if (cnt == 5'd0) begin
            cnt <= 5'd31;
            if (!sel_z) begin
              sel_z <= 1'b1;
              qx <= (dshift >= dden) ? {quo[30:0], 1'b1} : {quo[30:0], 1'b0};
              rem <= 33'(num_load[63:32]);
              num <= num_load[31:0];
            end else begin
              st <= S_DONE;
            end
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        S_DONE: st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  // the quotient reaches 2^31 at full width, so the offsets carry 33 bits
  logic [31:0] qz;
  assign qz = quo;
  always_comb begin
    off_x = sz ? $signed({1'b0, qz}) : -$signed({1'b0, qz});
    off_z = sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_x <= in_x;
      cur_z <= in_z;
      cur_h <= in_h;
    end
    if (cmd.start_a) begin
      base_x <= pend_x;
      base_z <= pend_z;
      base_h <= pend_h;
    end
    if (cmd.start_b) begin
      base_x <= cur_x;
      base_z <= cur_z;
      base_h <= cur_h;
    end
    if (cmd.shift_hist) begin
      prior_x <= pend_x;
      prior_z <= pend_z;
      pend_x <= cur_x;
      pend_z <= cur_z;
      pend_h <= cur_h;
    end
  end

  assign sts.busy = (st != S_IDLE);
  assign sts.done = (st == S_DONE);
  assign sts.nonzero = nz;
  assign sts.same_pt = (cur_x == pend_x) && (cur_z == pend_z);
endmodule
`default_nettype wire

@@ rtl/pse_ctrl.sv @@
// Controller: sequences points through the datapath and emits vertices.
// Depends on pse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pse_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_last,
  output pse_pkg::pse_cmd_t      cmd,
  input  wire pse_pkg::pse_sts_t sts,
  output logic                   first_dir,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_side,
  output logic                   out_last
);
  import pse_pkg::*;

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_RUNA = 3'd1;
  localparam logic [2:0] C_EMTA = 3'd2;
  localparam logic [2:0] C_RUNB = 3'd3;
  localparam logic [2:0] C_EMTB = 3'd4;
  localparam logic [2:0] C_WAIT = 3'd5;
  localparam logic [2:0] C_HOLD = 3'd6;

  logic [2:0] state;
  logic [1:0] seen;
  logic last_q, side, kick;

  assign in_ready = (state == C_IDLE);
  assign first_dir = (seen == 2'd1);
  assign out_valid = (state == C_EMTA) || (state == C_EMTB);
  assign out_side = side;
  // last vertex: side 1 of B, or side 1 of A if no B pair follows
  assign out_last = side && ((state == C_EMTB) || !last_q || sts.same_pt);

  always_comb begin
    cmd = '0;
    cmd.load_in = in_valid && in_ready;
    cmd.start_a = (state == C_WAIT) && !kick;
    cmd.start_b = (state == C_WAIT) && kick;
    // shift history on a first point, or on a finished held point if more follow
    cmd.shift_hist = (state == C_HOLD)
                  || ((state == C_RUNA) && sts.done && !sts.nonzero && !last_q)
                  || ((state == C_EMTA) && out_ready && side && !last_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      seen <= 2'd0;
      side <= 1'b0;
      last_q <= 1'b0;
      kick <= 1'b0;
    end else begin
      unique case (state)
        C_IDLE: if (in_valid) begin
          last_q <= in_last;
          if (seen == 2'd0) begin
            if (!in_last) begin
              seen <= 2'd1;
              state <= C_HOLD;
            end
          end else begin
            kick <= 1'b0;
            state <= C_WAIT;
          end
        end
        C_HOLD: state <= C_IDLE;
        C_WAIT: state <= kick ? C_RUNB : C_RUNA;
        C_RUNA: if (sts.done) begin
          side <= 1'b0;
          state <= sts.nonzero ? C_EMTA : (last_q ? C_WAIT : C_IDLE);
          kick <= last_q;
          if (!sts.nonzero && !last_q) seen <= 2'd2;
        end
        C_EMTA: if (out_ready) begin
          side <= ~side;
          if (side) begin
            kick <= last_q;
            state <= last_q ? C_WAIT : C_IDLE;
            if (!last_q) seen <= 2'd2;
          end
        end
        C_RUNB: if (sts.done) begin
          side <= 1'b0;
          state <= sts.nonzero ? C_EMTB : C_IDLE;
          if (!sts.nonzero) seen <= 2'd0;
        end
        C_EMTB: if (out_ready) begin
          side <= ~side;
          if (side) begin
            state <= C_IDLE;
            seen <= 2'd0;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/polyline_stroke_extrude_unit.sv @@
// Top level of the polyline stroke extruder.
// Depends on pse_pkg, pse_ctrl, pse_datapath.
//
// channel  dir  contents
// s_axis   in   tdata = point_x, point_height, point_z; tlast = point_last
// m_axis   out  tdata = vertex_x, vertex_height, vertex_z, vertex_side,
//               vertex_color; tlast = run_last
// cfg      in   index 0 stroke_width, index 1 stroke_color
//
// One point at a time: a point with a direction goes through normalize, the
// squares, a 31-step square root, two 32-step divisions and two vertex
// transfers before the next point is taken; a last point adds the same work
// for its own pair. rst is synchronous and empties the strip. A stalled
// m_axis holds the controller in its emit state; s_axis_tready is high only
// when idle.
`timescale 1ns / 1ps
`default_nettype none
module polyline_stroke_extrude_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // point_x, point_height, point_z
  input  wire logic [pse_pkg::InDataW-1:0]    s_axis_tdata,
  input  wire logic                           s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // vertex_x, vertex_height, vertex_z, vertex_side, vertex_color, zero pad
  output logic [pse_pkg::OutDataW-1:0]        m_axis_tdata,
  output logic                                m_axis_tlast,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import pse_pkg::*;

  pse_cmd_t cmd;
  pse_sts_t sts;
  logic first_dir, side;
  logic [31:0] stroke_width, stroke_color, base_h;
  logic signed [31:0] base_x, base_z;
  logic signed [32:0] off_x, off_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      stroke_width <= WidthReset;
      stroke_color <= ColorReset;
    end else if (cfg_we) begin
      if (cfg_index == CfgWidth) stroke_width <= cfg_data;
      else stroke_color <= cfg_data;
    end
  end

  pse_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_last(s_axis_tlast),
    .cmd, .sts, .first_dir,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_side(side), .out_last(m_axis_tlast)
  );

  pse_datapath u_dp (
    .clk, .rst, .cmd, .sts,
    .in_x(s_axis_tdata[31:0]), .in_h(s_axis_tdata[63:32]),
    .in_z(s_axis_tdata[95:64]),
    .first_dir, .stroke_width,
    .off_x, .off_z, .base_x, .base_z, .base_h
  );

  logic signed [32:0] vx, vz;
  logic [31:0] sx, sz;
  assign vx = side ? 33'(base_x) - off_x : 33'(base_x) + off_x;
  assign vz = side ? 33'(base_z) - off_z : 33'(base_z) + off_z;
  assign sx = (vx[32] != vx[31]) ? {vx[32], {31{~vx[32]}}} : vx[31:0];
  assign sz = (vz[32] != vz[31]) ? {vz[32], {31{~vz[32]}}} : vz[31:0];
  assign m_axis_tdata = {7'd0, stroke_color, side, sz, base_h, sx};

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    sts.busy |-> !s_axis_tready) else $error("input taken while busy");
  a_no_out_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("output while idle");
`endif
endmodule
`default_nettype wire

@@ verif/polyline_stroke_extrude_unit_test.sv @@
// Testbench for polyline_stroke_extrude_unit: drives polylines, predicts vertices.
// Depends on pse_pkg and the RTL of the extruder; self-checking, no files.
`timescale 1ns / 1ps
`default_nettype none
module polyline_stroke_extrude_unit_test;
  import pse_pkg::*;

  typedef struct {
    logic [31:0] x;
    logic [31:0] h;
    logic [31:0] z;
    logic        last;
  } point_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] h;
    logic [31:0] z;
    logic        side;
    logic [31:0] color;
    logic        last;
  } vertex_t;

  // directed row: point plus, where known at a glance, the vertex count it causes
  typedef struct {
    logic [31:0] x;
    logic [31:0] h;
    logic [31:0] z;
    logic        last;
    int          n_vert;  // -1 = not typed in
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_we = 1'b0;
  logic         cfg_index = CfgWidth;
  logic [31:0]  cfg_data = '0;

  polyline_stroke_extrude_unit dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [31:0] width_q = WidthReset;
  logic [31:0] color_q = ColorReset;
  longint prior_x, prior_z, held_x, held_z, held_h;
  int strip_pts;
  vertex_t vert_q[$];
  int errors = 0;
  longint cycles = 0;
  bit stall_rx = 1'b0;

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // queue the two vertices of a point moved along the perpendicular of (dx, dz)
  function automatic void push_pair(longint px, longint ph, longint pz,
                                    longint dx, longint dz);
    longint unsigned ax, az, mx, len, qx, qz;
    longint ox, oz;
    vertex_t v;
    ax = dx < 0 ? -dx : dx;
    az = dz < 0 ? -dz : dz;
    if (ax == 0 && az == 0) return;
    mx = ax > az ? ax : az;
    while (mx >= (64'd1 << 30)) begin ax >>= 1; az >>= 1; mx >>= 1; end
    while (mx < (64'd1 << 29)) begin ax <<= 1; az <<= 1; mx <<= 1; end
    len = int_sqrt(ax * ax + az * az);
    qx = (ax * width_q + len) / (2 * len);
    qz = (az * width_q + len) / (2 * len);
    ox = dz < 0 ? longint'(qz) : -longint'(qz);
    oz = dx < 0 ? -longint'(qx) : longint'(qx);
    for (int s = 0; s < 2; s++) begin
      v.x = clamp32(s ? px - ox : px + ox);
      v.z = clamp32(s ? pz - oz : pz + oz);
      v.h = ph[31:0];
      v.side = s[0];
      v.color = color_q;
      v.last = 1'b0;
      vert_q.insert(vert_q.size(), v);
    end
  endfunction

  function automatic int predict_point(point_t p);
    longint px, ph, pz;
    int q_start;
    px = sx(p.x);
    ph = sx(p.h);
    pz = sx(p.z);
    q_start = vert_q.size();
    if (strip_pts == 0) begin
      if (!p.last) begin
        held_x = px; held_z = pz; held_h = ph;
        strip_pts = 1;
      end
      return 0;
    end
    if (strip_pts == 1) push_pair(held_x, held_h, held_z, px - held_x, pz - held_z);
    else push_pair(held_x, held_h, held_z, px - prior_x, pz - prior_z);
    if (p.last) begin
      push_pair(px, ph, pz, px - held_x, pz - held_z);
      strip_pts = 0;
    end else begin
      prior_x = held_x; prior_z = held_z;
      held_x = px; held_z = pz; held_h = ph;
      strip_pts = 2;
    end
    if (vert_q.size() > q_start) vert_q[$].last = 1'b1;
    return vert_q.size() - q_start;
  endfunction

  // receiver: stall pattern of its own, changed only at clock edges
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if ($urandom_range(0, 63) == 0) stall_rx <= ~stall_rx;
      m_axis_tready <= stall_rx ? ($urandom_range(0, 3) == 0)
                                : ($urandom_range(0, 7) != 0);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      vertex_t got, want;
      got.x = m_axis_tdata[31:0];
      got.h = m_axis_tdata[63:32];
      got.z = m_axis_tdata[95:64];
      got.side = m_axis_tdata[96];
      got.color = m_axis_tdata[128:97];
      got.last = m_axis_tlast;
      if (vert_q.size() == 0) begin
        $error("vertex transfer with none expected");
        errors++;
      end else begin
        want = vert_q.pop_front();
        if (got.x !== want.x) begin
          $error("vertex_x exp %h got %h", want.x, got.x); errors++;
        end
        if (got.h !== want.h) begin
          $error("vertex_height exp %h got %h", want.h, got.h); errors++;
        end
        if (got.z !== want.z) begin
          $error("vertex_z exp %h got %h", want.z, got.z); errors++;
        end
        if (got.side !== want.side) begin
          $error("vertex_side exp %b got %b", want.side, got.side); errors++;
        end
        if (got.color !== want.color) begin
          $error("vertex_color exp %h got %h", want.color, got.color); errors++;
        end
        if (got.last !== want.last) begin
          $error("run_last exp %b got %b", want.last, got.last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 1000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  int gap_left = 0;

  // send one point; random gaps between bursts, valid held high inside a burst
  task automatic send_point(point_t p, int n_vert);
    int n;
    if (gap_left == 0 && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 60);
    if (gap_left > 0) s_axis_tvalid <= 1'b0;
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {p.z, p.h, p.x};
    s_axis_tlast <= p.last;
    do @(posedge clk); while (!s_axis_tready);
    n = predict_point(p);
    if (n_vert >= 0 && n != n_vert) begin
      $error("vertex count exp %0d predicted %0d", n_vert, n);
      errors++;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (vert_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgWidth) width_q = val;
    else color_q = val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                     : 32'h8000_0000 + $urandom_range(0, 255);
      default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0040_0000)
                                           : -$urandom_range(0, 32'h0040_0000);
    endcase
  endfunction

  row_t rows[] = '{
    '{32'h0, 32'h0, 32'h0, 1'b1, 0},                      // single point strip
    '{32'h0, 32'h0001_0000, 32'h0, 1'b0, 0},
    '{32'h0001_0000, 32'h0, 32'h0, 1'b1, 4},              // two point strip
    '{32'h0, 32'h0, 32'h0, 1'b0, 0},
    '{32'h0, 32'h5, 32'h0, 1'b0, 0},                      // zero direction
    '{32'h0002_0000, 32'h0, 32'h0003_0000, 1'b0, -1},
    '{32'h0002_0000, 32'h0, 32'h0003_0000, 1'b1, -1},     // repeated last point
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 0},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, -1},
    '{32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, -1},
    '{32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000, 1'b1, -1},
    '{32'h0, 32'h0, 32'h0, 1'b0, 0},
    '{32'h1, 32'h0, 32'h0, 1'b0, 2},                      // tiny step, scaled up
    '{32'h1, 32'h0, 32'hFFFF_FFFF, 1'b0, -1},
    '{32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h0, 1'b1, -1}
  };

  initial begin
    point_t p;
    int len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      p = '{rows[i].x, rows[i].h, rows[i].z, rows[i].last};
      send_point(p, rows[i].n_vert);
    end
    drain();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_reg(CfgWidth, 32'hFFFF_FFFF); write_reg(CfgColor, 32'h0); end
        1: begin write_reg(CfgWidth, 32'h0); write_reg(CfgColor, $urandom()); end
        2: write_reg(CfgWidth, $urandom());
        3: begin write_reg(CfgWidth, 32'h0004_0000); write_reg(CfgColor, 32'h1234_ABCD); end
        default: begin
          write_reg(CfgWidth, $urandom_range(1, 255));
          write_reg(CfgColor, $urandom());
        end
      endcase
      for (int k = 0; k < 56; ) begin
        len = $urandom_range(0, 7) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 9);
        for (int j = 0; j < len; j++, k++) begin
          p.x = rnd_coord();
          p.z = rnd_coord();
          p.h = $urandom();
          // occasional repeats give zero directions
          if (j > 0 && $urandom_range(0, 9) == 0) begin
            p.x = s_axis_tdata[31:0];
            p.z = s_axis_tdata[95:64];
          end
          p.last = (j == len - 1) || ($urandom_range(0, 19) == 0);
          send_point(p, -1);
        end
        if (k > 28 && phase == 2) drain();
      end
      drain();
    end
    if (errors == 0 && vert_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (vert_q.size() != 0) $error("%0d vertices never arrived", vert_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/pse_pkg.sv
rtl/pse_datapath.sv
rtl/pse_ctrl.sv
rtl/polyline_stroke_extrude_unit.sv
verif/polyline_stroke_extrude_unit_test.sv
